### rtl/core/bgs_pkg.sv
// shared constants and types for the box grid subdivider
package bgs_pkg;

  localparam int MaxSlabs     = 4;
  localparam int CoordW       = 32;
  localparam int SlabSizeW    = 31;
  localparam int NumAxes      = 3;
  localparam int SlabSizeRst  = 65536;

  typedef struct packed {
    logic                     empty;
    logic                     covered;
    logic signed [CoordW-1:0] bound;
  } slab_res_t;

endpackage

### rtl/core/bgs_slab_unit.sv
// shared slab step: advances k*step, clamps the next bound, checks coverage
module bgs_slab_unit #(
  parameter int AccW = 35
) (
  input  logic signed [bgs_pkg::CoordW-1:0]    lo_i,
  input  logic signed [bgs_pkg::CoordW-1:0]    hi_i,
  input  logic        [AccW-1:0]               acc_i,
  input  logic        [bgs_pkg::SlabSizeW-1:0] step_i,
  output logic        [AccW-1:0]               acc_o,
  output bgs_pkg::slab_res_t                   res_o
);
  import bgs_pkg::*;

  localparam int SumW = AccW + 1;

  logic signed [CoordW:0] ext;
  logic signed [SumW-1:0] sum;

  always_comb begin
    ext = {hi_i[CoordW-1], hi_i} - {lo_i[CoordW-1], lo_i};
    acc_o = acc_i + AccW'(step_i);
    sum = SumW'(lo_i) + signed'({1'b0, acc_o});
    res_o.empty = ext[CoordW] || (ext == '0);
    res_o.covered = (acc_o >= AccW'(ext));
    res_o.bound = (sum < SumW'(hi_i)) ? sum[CoordW-1:0] : hi_i;
  end

endmodule

### rtl/core/box_grid_subdivider_top.sv
// box grid subdivider: slab bound sequencer, bound storage and grid emitter
//
//  channel   | dir | handshake                      | payload
//  s_axis    | in  | s_axis_tvalid_i/s_axis_tready_o | box min xyz, max xyz
//  m_axis    | out | m_axis_tvalid_o/m_axis_tready_i | sub-box, tlast, tuser
//  cfg       | in  | cfg_we_i                        | slab_size
//
// a box is accepted, then the shared slab adder steps through up to MAX_SLABS slabs per
// axis, x then y then z, then one sub-box beat per cycle goes out unless the output stalls
// reset clears control and loads the reset slab size; bound tables and payload hold no reset value
// an empty axis ends the box as soon as it is seen, with no beats
// output stalls hold the beat register and stop the grid counters
module box_grid_subdivider_top #(
  parameter int MAX_SLABS = bgs_pkg::MaxSlabs
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [30:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [191:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // sub_min_x, sub_min_y, sub_min_z, sub_max_x, sub_max_y, sub_max_z
  output logic [191:0] m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  // truncated
  output logic         m_axis_tuser_o
);
  import bgs_pkg::*;

  localparam int SlabW = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int CntW  = $clog2(MAX_SLABS + 1);
  localparam int AccW  = 32 + $clog2(MAX_SLABS + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCalc = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [1:0]             axis_q, axis_d;
  logic [CntW-1:0]        k_q, k_d;
  logic [AccW-1:0]        acc_q, acc_d, acc_nxt;
  logic                   trunc_q, trunc_d;
  logic [SlabSizeW-1:0]   slab_size_q;
  logic [SlabSizeW-1:0]   step;
  logic [SlabW-1:0]       xlast_q, ylast_q, zlast_q;
  logic [SlabW-1:0]       x_q, y_q, z_q, x_d, y_d, z_d;
  logic [SlabW-1:0]       kidx, kpos;
  logic [CntW-1:0]        km1;
  logic signed [CoordW-1:0] box_min_q [NumAxes];
  logic signed [CoordW-1:0] box_max_q [NumAxes];
  logic signed [CoordW-1:0] smin_x_q [MAX_SLABS];
  logic signed [CoordW-1:0] smin_y_q [MAX_SLABS];
  logic signed [CoordW-1:0] smin_z_q [MAX_SLABS];
  logic signed [CoordW-1:0] smax_x_q [MAX_SLABS];
  logic signed [CoordW-1:0] smax_y_q [MAX_SLABS];
  logic signed [CoordW-1:0] smax_z_q [MAX_SLABS];
  logic signed [CoordW-1:0] lo, hi;
  slab_res_t              res;
  logic                   in_fire, out_free, k_at_max, axis_done, grid_last;
  logic                   out_valid_q;
  logic [191:0]           out_data_q;
  logic                   out_last_q, out_user_q;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign step     = (slab_size_q == '0) ? SlabSizeW'(1) : slab_size_q;
  assign lo       = box_min_q[axis_q];
  assign hi       = box_max_q[axis_q];
  assign km1      = k_q - CntW'(1);
  assign kidx     = km1[SlabW-1:0];
  assign kpos     = k_q[SlabW-1:0];
  assign k_at_max = (k_q == CntW'(MAX_SLABS));
  assign axis_done = res.covered || k_at_max;
  assign grid_last = (x_q == xlast_q) && (y_q == ylast_q) && (z_q == zlast_q);

  bgs_slab_unit #(
    .AccW(AccW)
  ) u_slab (
    .lo_i  (lo),
    .hi_i  (hi),
    .acc_i (acc_q),
    .step_i(step),
    .acc_o (acc_nxt),
    .res_o (res)
  );

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    k_d     = k_q;
    acc_d   = acc_q;
    trunc_d = trunc_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StCalc;
          axis_d  = AxisX;
          k_d     = CntW'(1);
          acc_d   = '0;
          trunc_d = 1'b0;
        end
      end
      StCalc: begin
        if (res.empty) begin
          state_d = StIdle;
        end else if (axis_done) begin
          trunc_d = trunc_q || !res.covered;
          k_d     = CntW'(1);
          acc_d   = '0;
          if (axis_q == AxisZ) begin
            state_d = StEmit;
            x_d = '0;
            y_d = '0;
            z_d = '0;
          end else begin
            axis_d = axis_q + 2'd1;
          end
        end else begin
          k_d   = k_q + CntW'(1);
          acc_d = acc_nxt;
        end
      end
      StEmit: begin
        if (out_free) begin
          if (grid_last) begin
            state_d = StIdle;
          end else if (z_q != zlast_q) begin
            z_d = z_q + SlabW'(1);
          end else if (y_q != ylast_q) begin
            z_d = '0;
            y_d = y_q + SlabW'(1);
          end else begin
            z_d = '0;
            y_d = '0;
            x_d = x_q + SlabW'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      axis_q      <= AxisX;
      k_q         <= CntW'(1);
      acc_q       <= '0;
      trunc_q     <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      slab_size_q <= SlabSizeW'(SlabSizeRst);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      k_q     <= k_d;
      acc_q   <= acc_d;
      trunc_q <= trunc_d;
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      if (cfg_we_i) begin
        slab_size_q <= cfg_wdata_i;
      end
      if (state_q == StEmit && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // box capture, bound tables and the beat register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int a = 0; a < NumAxes; a++) begin
        box_min_q[a] <= s_axis_tdata_i[a*CoordW +: CoordW];
        box_max_q[a] <= s_axis_tdata_i[(a+NumAxes)*CoordW +: CoordW];
      end
    end
    if (state_q == StCalc && !res.empty) begin
      case (axis_q)
        AxisX: begin
          smax_x_q[kidx] <= res.bound;
          if (k_q == CntW'(1)) smin_x_q[0] <= lo;
          if (!k_at_max) smin_x_q[kpos] <= res.bound;
          if (axis_done) xlast_q <= kidx;
        end
        AxisY: begin
          smax_y_q[kidx] <= res.bound;
          if (k_q == CntW'(1)) smin_y_q[0] <= lo;
          if (!k_at_max) smin_y_q[kpos] <= res.bound;
          if (axis_done) ylast_q <= kidx;
        end
        AxisZ: begin
          smax_z_q[kidx] <= res.bound;
          if (k_q == CntW'(1)) smin_z_q[0] <= lo;
          if (!k_at_max) smin_z_q[kpos] <= res.bound;
          if (axis_done) zlast_q <= kidx;
        end
        default: ;
      endcase
    end
    if (state_q == StEmit && out_free) begin
      out_data_q <= {smax_z_q[z_q], smax_y_q[y_q], smax_x_q[x_q],
                     smin_z_q[z_q], smin_y_q[y_q], smin_x_q[x_q]};
      out_last_q <= grid_last;
      out_user_q <= trunc_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef SYNTHESIS
  a_last_ends_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && out_free && grid_last) |=> (state_q == StIdle))
    else $error("box did not end after last beat");

  a_grid_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (x_q <= xlast_q && y_q <= ylast_q && z_q <= zlast_q))
    else $error("grid counter beyond slab count");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == StCalc && axis_q == AxisX && k_q == CntW'(1)))
    else $error("accepted box did not start at x axis");

  a_beat_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q)) |-> ($past(state_q) == StEmit))
    else $error("beat raised outside emit");
`endif

endmodule

### tb/sv/tb_box_grid_subdivider_top.sv
// self-checking bench for box_grid_subdivider_top: boxes in, checked grid of sub-boxes out
`timescale 1ns / 1ps

module tb_box_grid_subdivider_top;
  import bgs_pkg::*;

  localparam int SettleCycles = 40;
  localparam int BoxW         = 2 * NumAxes * CoordW;
  localparam int PhaseBoxes   = 41;

  typedef struct packed {
    logic [BoxW-1:0] corners;
    logic            last;
    logic            cut;
  } sub_box_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [SlabSizeW-1:0] cfg_wdata_i     = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [BoxW-1:0]      s_axis_tdata_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [BoxW-1:0]      m_axis_tdata_o;
  logic                 m_axis_tlast_o;
  logic                 m_axis_tuser_o;

  logic [BoxW-1:0]      box_queue[$];
  sub_box_t             grid_expect[$];
  logic [SlabSizeW-1:0] slab_size_q = SlabSizeW'(SlabSizeRst);

  logic in_fire_q  = 1'b0;
  logic out_fire_q = 1'b0;
  int   in_gap     = 0;
  int   out_stall  = 0;
  bit   in_quiet   = 1'b0;
  bit   out_quiet  = 1'b0;

  int mismatches  = 0;
  int boxes_in    = 0;
  int boxes_empty = 0;
  int boxes_cut   = 0;
  int beats_seen  = 0;

  string field_name[6] = '{"sub_min_x", "sub_min_y", "sub_min_z",
                           "sub_max_x", "sub_max_y", "sub_max_z"};

  box_grid_subdivider_top #(
    .MAX_SLABS(MaxSlabs)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // slab bounds per axis, then the x-y-z product grid of sub-boxes
  task automatic predict_grid(input logic [BoxW-1:0] box);
    logic signed [63:0] step, lo, hi, ext, b;
    logic signed [63:0] bnd[NumAxes][MaxSlabs+1];
    int                 cnt[NumAxes];
    int                 a, k, x, y, z, n, total;
    logic               cut;
    sub_box_t           sb;
    step = (slab_size_q == '0) ? 64'sd1 : $signed({33'd0, slab_size_q});
    cut  = 1'b0;
    for (a = 0; a < NumAxes; a++) begin
      lo  = $signed(box[a*CoordW +: CoordW]);
      hi  = $signed(box[(a+NumAxes)*CoordW +: CoordW]);
      ext = hi - lo;
      if (ext <= 0) begin
        boxes_empty++;
        return;
      end
      cnt[a] = int'((ext + step - 1) / step);
      if (cnt[a] > MaxSlabs) begin
        cnt[a] = MaxSlabs;
        cut    = 1'b1;
      end
      for (k = 0; k <= cnt[a]; k++) begin
        b         = lo + k * step;
        bnd[a][k] = (b < hi) ? b : hi;
      end
    end
    if (cut) boxes_cut++;
    total = cnt[0] * cnt[1] * cnt[2];
    n     = 0;
    for (x = 0; x < cnt[0]; x++)
      for (y = 0; y < cnt[1]; y++)
        for (z = 0; z < cnt[2]; z++) begin
          n          = n + 1;
          sb.corners = {bnd[2][z+1][31:0], bnd[1][y+1][31:0], bnd[0][x+1][31:0],
                        bnd[2][z][31:0], bnd[1][y][31:0], bnd[0][x][31:0]};
          sb.last    = (n == total);
          sb.cut     = cut;
          grid_expect = {grid_expect, sb};
        end
  endtask

  // mostly boxes of 1..5 slabs per axis, some fully random, some with an empty axis
  function automatic logic [BoxW-1:0] random_box();
    logic [BoxW-1:0]    box;
    logic [63:0]        step, ext, r;
    logic signed [63:0] lo;
    logic signed [31:0] p, q, t;
    int                 kind, a, bad;
    step = (slab_size_q == '0) ? 64'd1 : {33'd0, slab_size_q};
    kind = $urandom_range(0, 9);
    bad  = (kind >= 8) ? $urandom_range(0, NumAxes - 1) : -1;
    for (a = 0; a < NumAxes; a++) begin
      if (kind == 7) begin
        box[a*CoordW +: CoordW]           = $urandom;
        box[(a+NumAxes)*CoordW +: CoordW] = $urandom;
      end else if (a == bad) begin
        p = $urandom;
        q = $urandom;
        if ($urandom_range(0, 3) == 0) q = p;
        if (p < q) begin
          t = p;
          p = q;
          q = t;
        end
        box[a*CoordW +: CoordW]           = p;
        box[(a+NumAxes)*CoordW +: CoordW] = q;
      end else begin
        ext = 64'($urandom_range(0, MaxSlabs)) * step;
        ext = ext + (($urandom_range(0, 2) == 0) ? step : 64'($urandom_range(1, step[31:0])));
        if (ext > 64'hFFFF_FFFF) ext = 64'hFFFF_FFFF;
        r  = {$urandom, $urandom} % (64'h1_0000_0000 - ext);
        lo = $signed(r) - 64'sd2147483648;
        box[a*CoordW +: CoordW]           = lo[31:0];
        box[(a+NumAxes)*CoordW +: CoordW] = lo[31:0] + ext[31:0];
      end
    end
    return box;
  endfunction

  task automatic push_box(input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] lz,
                          input logic [31:0] hx, input logic [31:0] hy, input logic [31:0] hz);
    box_queue = {box_queue, {hz, hy, hx, lz, ly, lx}};
  endtask

  task automatic write_slab(input logic [SlabSizeW-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    slab_size_q = v;
  endtask

  // empty boxes leave no trace in the expectations, so let the block settle too
  task automatic drain();
    do @(posedge clk_i);
    while (box_queue.size() != 0 || s_axis_tvalid_i || grid_expect.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    sub_box_t want;
    int       i;
    in_fire_q  <= s_axis_tvalid_i && s_axis_tready_o;
    out_fire_q <= m_axis_tvalid_o && m_axis_tready_i;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      beats_seen++;
      if (grid_expect.size() == 0) begin
        mismatches++;
        $display("%0t unexpected sub-box beat: expected none, got %h last %b trunc %b",
                 $time, m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
      end else begin
        want = grid_expect.pop_front();
        for (i = 0; i < 2 * NumAxes; i++)
          if (m_axis_tdata_o[i*CoordW +: CoordW] !== want.corners[i*CoordW +: CoordW]) begin
            mismatches++;
            $display("%0t mismatch %s: expected %h, got %h", $time, field_name[i],
                     want.corners[i*CoordW +: CoordW], m_axis_tdata_o[i*CoordW +: CoordW]);
          end
        if (m_axis_tlast_o !== want.last) begin
          mismatches++;
          $display("%0t mismatch last_sub_box: expected %b, got %b", $time, want.last,
                   m_axis_tlast_o);
        end
        if (m_axis_tuser_o !== want.cut) begin
          mismatches++;
          $display("%0t mismatch truncated: expected %b, got %b", $time, want.cut,
                   m_axis_tuser_o);
        end
      end
    end
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      boxes_in++;
      predict_grid(s_axis_tdata_i);
    end
  end

  // box driver: one pending box at a time, random gap before each
  always @(negedge clk_i) begin
    logic            nv;
    logic [BoxW-1:0] nd;
    nv = s_axis_tvalid_i;
    nd = s_axis_tdata_i;
    if (rst_ni) begin
      if (nv && in_fire_q) begin
        nv = 1'b0;
        if ($urandom_range(0, 15) == 0) in_quiet = !in_quiet;
        in_gap = in_quiet ? 0 : $urandom_range(0, 12);
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (box_queue.size() != 0) begin
          nd = box_queue.pop_front();
          nv = 1'b1;
        end
      end
    end
    s_axis_tvalid_i <= nv;
    s_axis_tdata_i  <= nd;
  end

  // sink back-pressure: random stall before each beat
  always @(negedge clk_i) begin
    logic nr;
    nr = m_axis_tready_i;
    if (rst_ni) begin
      if (out_fire_q) begin
        if ($urandom_range(0, 15) == 0) out_quiet = !out_quiet;
        out_stall = out_quiet ? 0 : $urandom_range(0, 12);
      end
      if (out_stall > 0) begin
        out_stall--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
    end
    m_axis_tready_i <= nr;
  end

  initial begin
    logic [SlabSizeW-1:0] slab_plan[7];
    int                   p, i;
    slab_plan[0] = 31'd1;
    slab_plan[1] = 31'd0;
    slab_plan[2] = 31'h7FFF_FFFF;
    slab_plan[3] = 31'h0000_4000;
    slab_plan[4] = 31'($urandom_range(1, 32'h7FFF_FFFF));
    slab_plan[5] = 31'($urandom_range(1, 32'h0003_0000));
    slab_plan[6] = 31'd65536;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset slab size of 1.0
    push_box(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
             32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    push_box(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
             32'h0004_0000, 32'h0004_0000, 32'h0004_0000);
    push_box(32'hFFFE_0000, 32'hFFFE_0000, 32'hFFFE_0000,
             32'h0001_8000, 32'h0000_4000, 32'h0002_0000);
    push_box(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
             32'h0005_0000, 32'h0001_0000, 32'h0001_0000);
    push_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_box(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
             32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    push_box(32'h7FFF_FFFE, 32'h7FFF_0000, 32'h7FFC_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8004_0000, 32'h8003_0001, 32'h8000_FFFF);
    push_box(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
             32'h0000_8000, 32'h0004_0000, 32'h0006_0000);
    // empty on one axis: equal corners, reversed corners, widest reversal
    push_box(32'h0002_0000, 32'h0000_0000, 32'h0000_0000,
             32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
    push_box(32'h0000_0000, 32'h0003_0000, 32'h0000_0000,
             32'h0001_0000, 32'h0002_FFFF, 32'h0001_0000);
    push_box(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF,
             32'h0001_0000, 32'h0001_0000, 32'h8000_0000);
    push_box(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
             32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_box(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
             32'h5557_5555, 32'hAAAC_AAAB, 32'h0F11_8000);
    drain();

    for (p = 0; p < 7; p++) begin
      write_slab(slab_plan[p]);
      for (i = 0; i < PhaseBoxes; i++) box_queue = {box_queue, random_box()};
      drain();
    end

    $display("covered %0d boxes over 8 slab sizes incl. 0, 1 and the maximum", boxes_in);
    $display("%0d boxes empty, %0d over the slab limit, %0d sub-box beats checked",
             boxes_empty, boxes_cut, beats_seen);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d sub-boxes still expected", grid_expect.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
